// File: rtl/core/pcs_pkg.sv
package pcs_pkg;

    localparam int unsigned TargetW  = 23;
    localparam int unsigned PostW    = 4;
    localparam int unsigned RefW     = 16;
    localparam int unsigned MW       = 4;
    localparam int unsigned NW       = 8;
    localparam int unsigned FreqW    = 24;
    localparam int unsigned WordW    = 20;
    localparam int unsigned DivBits  = FreqW;
    localparam int unsigned CntW     = $clog2(DivBits);

    localparam logic [RefW-1:0]    RefReset      = 16'd13500;
    localparam logic [RefW-1:0]    RefSpecial    = 16'd14318;
    localparam logic [TargetW-1:0] TargetMid     = 23'd250000;
    localparam logic [TargetW-1:0] TargetHigh    = 23'd340000;
    localparam logic [NW-1:0]      NMin          = 8'd14;
    localparam logic [NW-1:0]      NMaxLow       = 8'd255;
    localparam logic [NW-1:0]      NMaxHigh      = 8'd93;
    localparam logic [CntW-1:0]    DivLast       = CntW'(DivBits - 1);

    typedef struct packed {
        logic [TargetW-1:0] target_khz;
        logic [PostW-1:0]   current_post_div;
    } t_in;

    typedef struct packed {
        logic [WordW-1:0] pll_word;
        logic [FreqW-1:0] achieved_khz;
        logic [FreqW-1:0] error_khz;
        logic             found;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic eval;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_cand;
    } t_sts;

endpackage

// File: rtl/core/pll_coefficient_search.sv
// each (m, n) candidate passes through S_MUL, S_DIV and S_EVAL between start and o_done
//   up to 8 x 242 candidates for targets up to 250 MHz, 6 x 80 up to 340 MHz,
//   2 x 80 above; the divider produces one quotient bit per cycle
// throughput: one request at a time, busy high until the result beat
// o_done pulses for one cycle with o_result; the receiver cannot stall
// synchronous active-low reset: idle, reference back to 13500 kHz
module pll_coefficient_search (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [pcs_pkg::RefW-1:0] i_cfg_data,
    input  logic                     start,
    output logic                     busy,
    input  pcs_pkg::t_in             i_in,
    output logic                     o_done,
    output pcs_pkg::t_out            o_result
);

    pcs_pkg::t_cmd s_cmd;
    pcs_pkg::t_sts s_sts;

    pcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    pcs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (s_cmd),
        .o_sts      (s_sts),
        .o_result   (o_result)
    );

endmodule

// File: rtl/core/pcs_ctrl.sv
module pcs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pcs_pkg::t_sts i_sts,
    output pcs_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_EVAL = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                   r_state, n_state;
    logic [pcs_pkg::CntW-1:0] r_bit_cnt, n_bit_cnt;

    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_bit_cnt = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_bit_cnt  = r_bit_cnt + 1'b1;
                if (r_bit_cnt == pcs_pkg::DivLast) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.last_cand ? S_DONE : S_MUL;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

// File: rtl/core/pcs_dp.sv
module pcs_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pcs_pkg::RefW-1:0]  i_cfg_data,
    input  pcs_pkg::t_in              i_in,
    input  pcs_pkg::t_cmd             i_cmd,
    output pcs_pkg::t_sts             o_sts,
    output pcs_pkg::t_out             o_result
);

    logic [pcs_pkg::RefW-1:0]    r_ref;
    logic [pcs_pkg::TargetW-1:0] r_target;
    logic [pcs_pkg::PostW-1:0]   r_p;
    logic [pcs_pkg::MW-1:0]      r_m, r_m_hi;
    logic [pcs_pkg::NW-1:0]      r_n, r_n_hi;
    logic [pcs_pkg::FreqW-1:0]   r_quo;
    logic [pcs_pkg::MW-1:0]      r_rem;
    logic [pcs_pkg::FreqW-1:0]   r_best_err, r_best_f;
    logic [pcs_pkg::MW-1:0]      r_best_m;
    logic [pcs_pkg::NW-1:0]      r_best_n;
    logic                        r_found;

    logic [pcs_pkg::MW-1:0]      n_m_lo, n_m_hi;
    logic [pcs_pkg::NW-1:0]      n_n_hi;
    logic [pcs_pkg::MW:0]        s_trial;
    logic                        s_ge;
    logic [pcs_pkg::FreqW-1:0]   s_f, s_tgt, s_d;
    logic                        s_better;

    // search limits for the new request
    always_comb begin
        if (r_ref == pcs_pkg::RefSpecial) begin
            n_m_lo = 4'd7;
            n_m_hi = 4'd14;
        end else begin
            n_m_lo = 4'd6;
            n_m_hi = 4'd13;
        end
        n_n_hi = pcs_pkg::NMaxLow;
        if (i_in.target_khz > pcs_pkg::TargetMid) begin
            n_m_lo = 4'd1;
            n_m_hi = 4'd6;
            n_n_hi = pcs_pkg::NMaxHigh;
        end
        if (i_in.target_khz > pcs_pkg::TargetHigh) begin
            n_m_lo = 4'd1;
            n_m_hi = 4'd2;
            n_n_hi = pcs_pkg::NMaxHigh;
        end
    end

    // restoring division, one quotient bit per cycle
    assign s_trial = {r_rem, r_quo[pcs_pkg::FreqW-1]};
    assign s_ge    = (s_trial >= {1'b0, r_m});

    assign s_f      = r_quo >> r_p;
    assign s_tgt    = {1'b0, r_target};
    assign s_d      = (s_f > s_tgt) ? (s_f - s_tgt) : (s_tgt - s_f);
    assign s_better = (s_d < r_best_err);

    assign o_sts.last_cand = (r_n == r_n_hi) && (r_m == r_m_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref   <= pcs_pkg::RefReset;
            r_found <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ref <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (i_cmd.eval && s_better) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target   <= i_in.target_khz;
            r_p        <= i_in.current_post_div;
            r_m        <= n_m_lo;
            r_m_hi     <= n_m_hi;
            r_n        <= pcs_pkg::NMin;
            r_n_hi     <= n_n_hi;
            r_best_err <= {1'b0, i_in.target_khz};
            r_best_f   <= '0;
            r_best_m   <= '0;
            r_best_n   <= '0;
        end
        if (i_cmd.mul) begin
            r_quo <= pcs_pkg::FreqW'(r_n * r_ref);
            r_rem <= '0;
        end
        if (i_cmd.step) begin
            r_rem <= s_ge ? pcs_pkg::MW'(s_trial - {1'b0, r_m}) : s_trial[pcs_pkg::MW-1:0];
            r_quo <= {r_quo[pcs_pkg::FreqW-2:0], s_ge};
        end
        if (i_cmd.eval) begin
            if (s_better) begin
                r_best_err <= s_d;
                r_best_f   <= s_f;
                r_best_m   <= r_m;
                r_best_n   <= r_n;
            end
            if (r_n == r_n_hi) begin
                r_n <= pcs_pkg::NMin;
                r_m <= r_m + 1'b1;
            end else begin
                r_n <= r_n + 1'b1;
            end
        end
    end

    always_comb begin
        o_result = '0;
        if (r_found) begin
            o_result.pll_word     = {r_p, r_best_n, 4'd0, r_best_m};
            o_result.achieved_khz = r_best_f;
            o_result.error_khz    = r_best_err;
            o_result.found        = 1'b1;
        end
    end

endmodule

// File: rtl/core/pcs_checker.sv
module pcs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input pcs_pkg::t_out o_result
);

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result beat without a request in flight");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("block not idle after result beat");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.found) |->
            (o_result.pll_word == '0 && o_result.achieved_khz == '0 &&
             o_result.error_khz == '0))
        else $error("fields not cleared when no candidate found");

    a_found_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.found) |-> (o_result.pll_word[7:0] != 8'd0))
        else $error("found result with m of zero");

endmodule

bind pll_coefficient_search pcs_checker u_pcs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
